>>> hdl/p11s_pkg.sv
// ----------------------------------------------------------------------------
// p11s_pkg
// Shared types, constants and helpers for the PDP-11 subset step unit.
// ----------------------------------------------------------------------------
package p11s_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int HALF_WORDS = MEM_BYTES / 2;

    localparam logic [15:0] CONSOLE_RESET = 16'd65398;
    localparam logic [15:0] PC_RESET      = 16'd512;

    typedef enum logic [3:0] {
        K_HALT    = 4'd0,
        K_MOV     = 4'd1,
        K_MOVB    = 4'd2,
        K_ADD     = 4'd3,
        K_SOB     = 4'd4,
        K_CLR     = 4'd5,
        K_BEQ     = 4'd6,
        K_BPL     = 4'd7,
        K_BR      = 4'd8,
        K_TST     = 4'd9,
        K_TSTB    = 4'd10,
        K_JSR     = 4'd11,
        K_RTS     = 4'd12,
        K_UNKNOWN = 4'd13,
        K_LOAD    = 4'd14
    } kind_t;

    localparam int NUM_DEC = 13;

    localparam logic [15:0] DEC_MASK [NUM_DEC] = '{
        16'hFFFF, 16'o170000, 16'o170000, 16'o170000, 16'o177000, 16'o177700,
        16'o177400, 16'o177400, 16'o177400, 16'o177700, 16'o177700,
        16'o177000, 16'o177770
    };
    localparam logic [15:0] DEC_CODE [NUM_DEC] = '{
        16'o000000, 16'o010000, 16'o110000, 16'o060000, 16'o077000, 16'o005000,
        16'o001400, 16'o100000, 16'o000400, 16'o005700, 16'o105700,
        16'o004000, 16'o000200
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_FETCH,
        S_FETCH_W,
        S_DECODE,
        S_RES,
        S_RES_X,
        S_RES_IND,
        S_OPRD,
        S_OPRD_MEM,
        S_MOV_WB,
        S_ADD_WB,
        S_CLR_WB,
        S_TST_NZ,
        S_SOB2,
        S_JSR1,
        S_JSR2,
        S_JSR3,
        S_RTS2,
        S_RTS3,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_FETCH,
        OP_LATCH_IR,
        OP_RES,
        OP_RES_X,
        OP_RES_IND,
        OP_OPRD,
        OP_OPRD_MEM,
        OP_MOV_WB,
        OP_ADD_WB,
        OP_CLR_WB,
        OP_TST_NZ,
        OP_HALT,
        OP_SOB1,
        OP_SOB2,
        OP_BRANCH,
        OP_JSR1,
        OP_JSR2,
        OP_JSR3,
        OP_RTS1,
        OP_RTS2,
        OP_RTS3,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] instr_address;
        logic [15:0] instr_word;
        logic [3:0]  instr_kind;
        logic        halted;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        flag_n;
        logic        flag_z;
    } out_item_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel_dst;
    } dp_cmd_t;

    typedef struct packed {
        kind_t      kind;
        logic [2:0] mode;
        logic       in_reg;
        logic       halted;
        logic       jsr_indirect;
    } dp_status_t;

    function automatic logic [15:0] sext8(logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    // first matching table entry wins
    function automatic kind_t decode_kind(logic [15:0] w);
        kind_t k;
        k = K_UNKNOWN;
        for (int i = NUM_DEC - 1; i >= 0; i--) begin
            if ((w & DEC_MASK[i]) == DEC_CODE[i])
            begin
                k = kind_t'(4'(i));
            end
        end
        return k;
    endfunction

endpackage

>>> hdl/p11s_ctrl.sv
// ----------------------------------------------------------------------------
// p11s_ctrl
// Sequencer: walks fetch, operand resolution and execute steps, drives
// datapath commands and the channel handshakes.
// ----------------------------------------------------------------------------
module p11s_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_opcode,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output p11s_pkg::dp_cmd_t     cmd,
    input  p11s_pkg::dp_status_t  status
);
    import p11s_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   out_valid_reg, out_valid_next;
    state_t after_res;
    state_t after_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // where to go once an operand address is known
    always_comb
    begin
        if (!phase_reg || status.kind == K_ADD || status.kind == K_TST ||
            status.kind == K_TSTB)
        begin
            after_res = S_OPRD;
        end
        else if (status.kind == K_MOV || status.kind == K_MOVB)
        begin
            after_res = S_MOV_WB;
        end
        else if (status.kind == K_CLR)
        begin
            after_res = S_CLR_WB;
        end
        else
        begin
            after_res = S_JSR1;
        end

        if (!phase_reg)
        begin
            after_read = S_RES;
        end
        else if (status.kind == K_ADD)
        begin
            after_read = S_ADD_WB;
        end
        else
        begin
            after_read = S_TST_NZ;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cmd.op      = OP_NONE;
        cmd.sel_dst = phase_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (!in_opcode)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (status.halted)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                cmd.op     = OP_FETCH;
                state_next = S_FETCH_W;
            end
            S_FETCH_W:
            begin
                cmd.op     = OP_LATCH_IR;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (status.kind)
                    K_HALT:
                    begin
                        cmd.op     = OP_HALT;
                        state_next = S_DONE;
                    end
                    K_MOV, K_MOVB, K_ADD:
                    begin
                        phase_next = 1'b0;
                        state_next = S_RES;
                    end
                    K_CLR, K_TST, K_TSTB:
                    begin
                        phase_next = 1'b1;
                        state_next = S_RES;
                    end
                    K_JSR:
                    begin
                        phase_next = 1'b1;
                        state_next = status.jsr_indirect ? S_RES : S_DONE;
                    end
                    K_SOB:
                    begin
                        cmd.op     = OP_SOB1;
                        state_next = S_SOB2;
                    end
                    K_BEQ, K_BPL, K_BR:
                    begin
                        cmd.op     = OP_BRANCH;
                        state_next = S_DONE;
                    end
                    K_RTS:
                    begin
                        // register field sits in the low bits
                        cmd.op      = OP_RTS1;
                        cmd.sel_dst = 1'b1;
                        phase_next  = 1'b1;
                        state_next  = S_RTS2;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RES:
            begin
                cmd.op = OP_RES;
                case (status.mode)
                    3'd3, 3'd5: state_next = S_RES_IND;
                    3'd6, 3'd7: state_next = S_RES_X;
                    default:    state_next = after_res;
                endcase
            end
            S_RES_X:
            begin
                cmd.op     = OP_RES_X;
                state_next = (status.mode == 3'd7) ? S_RES_IND : after_res;
            end
            S_RES_IND:
            begin
                cmd.op     = OP_RES_IND;
                state_next = after_res;
            end
            S_OPRD:
            begin
                cmd.op = OP_OPRD;
                if (status.in_reg)
                begin
                    state_next = after_read;
                    phase_next = 1'b1;
                end
                else
                begin
                    state_next = S_OPRD_MEM;
                end
            end
            S_OPRD_MEM:
            begin
                cmd.op     = OP_OPRD_MEM;
                state_next = after_read;
                phase_next = 1'b1;
            end
            S_MOV_WB:
            begin
                cmd.op     = OP_MOV_WB;
                state_next = S_DONE;
            end
            S_ADD_WB:
            begin
                cmd.op     = OP_ADD_WB;
                state_next = S_DONE;
            end
            S_CLR_WB:
            begin
                cmd.op     = OP_CLR_WB;
                state_next = S_DONE;
            end
            S_TST_NZ:
            begin
                cmd.op     = OP_TST_NZ;
                state_next = S_DONE;
            end
            S_SOB2:
            begin
                cmd.op     = OP_SOB2;
                state_next = S_DONE;
            end
            S_JSR1:
            begin
                cmd.op     = OP_JSR1;
                state_next = S_JSR2;
            end
            S_JSR2:
            begin
                cmd.op     = OP_JSR2;
                state_next = S_JSR3;
            end
            S_JSR3:
            begin
                cmd.op     = OP_JSR3;
                state_next = S_DONE;
            end
            S_RTS2:
            begin
                cmd.op     = OP_RTS2;
                state_next = S_RTS3;
            end
            S_RTS3:
            begin
                cmd.op     = OP_RTS3;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the previous transaction has left the output
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_DONE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/p11s_dpath.sv
// ----------------------------------------------------------------------------
// p11s_dpath
// Datapath: register file, flags, byte memory in two banks, operand
// latches, console register and result register.
// ----------------------------------------------------------------------------
module p11s_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  p11s_pkg::dp_cmd_t     cmd,
    output p11s_pkg::dp_status_t  status,
    input  p11s_pkg::in_item_t    in_data,
    output p11s_pkg::out_item_t   out_data,
    input  logic                  cfg_write_en,
    input  logic [15:0]           cfg_write_data
);
    import p11s_pkg::*;

    logic [15:0] rf_reg [8];
    logic        n_reg, n_next;
    logic        z_reg, z_next;
    logic        h_reg, h_next;
    logic [15:0] console_reg;

    logic [15:0] ir_reg, ir_next;
    logic [15:0] addr_reg, addr_next;
    logic        inreg_reg, inreg_next;
    logic [15:0] sv_reg, sv_next;
    logic [15:0] dv_reg, dv_next;
    logic [15:0] iaddr_reg, iaddr_next;
    logic [7:0]  lbyte_reg, lbyte_next;
    logic        load_item_reg, load_item_next;
    logic        halt_snap_reg, halt_snap_next;
    logic        cvalid_reg, cvalid_next;
    logic [7:0]  char_reg, char_next;
    out_item_t   out_reg, out_next;

    logic [7:0] lo_mem [HALF_WORDS];
    logic [7:0] hi_mem [HALF_WORDS];
    logic [7:0] rd_lo_reg, rd_hi_reg;
    logic       rd_a0_reg;

    logic [15:0] mem_ra;
    logic        mem_we, mem_word;
    logic [15:0] mem_wa, mem_wd;
    logic        we_lo, we_hi;
    logic [7:0]  wd_hi;

    logic        wr_en;
    logic [2:0]  wr_idx;
    logic [15:0] wr_data;

    logic [5:0]  spec;
    logic [2:0]  mode, rn, rr, rd_idx;
    logic        byte_op;
    kind_t       kind;
    logic [15:0] rval, r6, r7, rword, step, t, val, boff, wb_val;
    logic [7:0]  rbyte;
    logic        take;

    function automatic logic [1:0] nz(logic [15:0] v, logic b);
        if (b)
        begin
            return {v[7], v[7:0] == 8'd0};
        end
        return {v[15], v == 16'd0};
    endfunction

    assign spec    = cmd.sel_dst ? ir_reg[5:0] : ir_reg[11:6];
    assign mode    = spec[5:3];
    assign rn      = spec[2:0];
    assign rr      = ir_reg[8:6];
    assign byte_op = ir_reg[15];
    assign kind    = decode_kind(ir_reg);
    assign rd_idx  = (cmd.op == OP_SOB1 || cmd.op == OP_SOB2 || cmd.op == OP_JSR2) ? rr : rn;
    assign rval    = rf_reg[rd_idx];
    assign r6      = rf_reg[6];
    assign r7      = rf_reg[7];
    assign rword   = {rd_hi_reg, rd_lo_reg};
    assign rbyte   = rd_a0_reg ? rd_hi_reg : rd_lo_reg;
    assign step    = (byte_op && rn < 3'd6) ? 16'd1 : 16'd2;
    assign boff    = sext8(ir_reg[7:0]);

    assign status.kind         = kind;
    assign status.mode         = mode;
    assign status.in_reg       = inreg_reg;
    assign status.halted       = h_reg;
    assign status.jsr_indirect = (ir_reg[5:3] != 3'd0);

    always_comb
    begin
        n_next         = n_reg;
        z_next         = z_reg;
        h_next         = h_reg;
        ir_next        = ir_reg;
        addr_next      = addr_reg;
        inreg_next     = inreg_reg;
        sv_next        = sv_reg;
        dv_next        = dv_reg;
        iaddr_next     = iaddr_reg;
        lbyte_next     = lbyte_reg;
        load_item_next = load_item_reg;
        halt_snap_next = halt_snap_reg;
        cvalid_next    = cvalid_reg;
        char_next      = char_reg;
        out_next       = out_reg;
        mem_ra   = r7;
        mem_we   = 1'b0;
        mem_word = 1'b1;
        mem_wa   = addr_reg;
        mem_wd   = 16'd0;
        wr_en    = 1'b0;
        wr_idx   = rn;
        wr_data  = 16'd0;
        t        = 16'd0;
        val      = 16'd0;
        wb_val   = 16'd0;
        take     = 1'b0;

        case (cmd.op)
            OP_ACCEPT:
            begin
                iaddr_next     = in_data.opcode ? r7 : in_data.load_address;
                lbyte_next     = in_data.load_byte;
                load_item_next = ~in_data.opcode;
                halt_snap_next = h_reg;
                ir_next        = 16'd0;
                cvalid_next    = 1'b0;
                char_next      = 8'd0;
            end
            OP_LOAD:
            begin
                mem_we   = 1'b1;
                mem_word = 1'b0;
                mem_wa   = iaddr_reg;
                mem_wd   = {8'd0, lbyte_reg};
            end
            OP_FETCH:
            begin
                mem_ra  = r7;
                wr_en   = 1'b1;
                wr_idx  = 3'd7;
                wr_data = r7 + 16'd2;
            end
            OP_LATCH_IR:
            begin
                ir_next = rword;
            end
            OP_RES:
            begin
                inreg_next = (mode == 3'd0);
                case (mode)
                    3'd1:
                    begin
                        addr_next = rval;
                    end
                    3'd2:
                    begin
                        addr_next = rval;
                        wr_en     = 1'b1;
                        wr_data   = rval + step;
                    end
                    3'd3:
                    begin
                        mem_ra  = rval;
                        wr_en   = 1'b1;
                        wr_data = rval + 16'd2;
                    end
                    3'd4:
                    begin
                        t         = rval - step;
                        addr_next = t;
                        wr_en     = 1'b1;
                        wr_data   = t;
                    end
                    3'd5:
                    begin
                        t       = rval - 16'd2;
                        mem_ra  = t;
                        wr_en   = 1'b1;
                        wr_data = t;
                    end
                    3'd6, 3'd7:
                    begin
                        mem_ra  = r7;
                        wr_en   = 1'b1;
                        wr_idx  = 3'd7;
                        wr_data = r7 + 16'd2;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_RES_X:
            begin
                // index word has arrived; pc already points past it
                t         = rval + rword;
                addr_next = t;
                mem_ra    = t;
            end
            OP_RES_IND:
            begin
                addr_next = rword;
            end
            OP_OPRD:
            begin
                mem_ra = addr_reg;
                val    = byte_op ? sext8(rval[7:0]) : rval;
                if (inreg_reg)
                begin
                    if (cmd.sel_dst)
                    begin
                        dv_next = val;
                    end
                    else
                    begin
                        sv_next = val;
                    end
                end
            end
            OP_OPRD_MEM:
            begin
                val = byte_op ? sext8(rbyte) : rword;
                if (cmd.sel_dst)
                begin
                    dv_next = val;
                end
                else
                begin
                    sv_next = val;
                end
            end
            OP_MOV_WB:
            begin
                {n_next, z_next} = nz(sv_reg, byte_op);
                if (!inreg_reg && addr_reg == console_reg)
                begin
                    cvalid_next = 1'b1;
                    char_next   = sv_reg[7:0];
                end
                else if (inreg_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = byte_op ? sext8(sv_reg[7:0]) : sv_reg;
                end
                else
                begin
                    mem_we   = 1'b1;
                    mem_word = ~byte_op;
                    mem_wd   = sv_reg;
                end
            end
            OP_ADD_WB, OP_CLR_WB:
            begin
                wb_val = (cmd.op == OP_ADD_WB) ? dv_reg + sv_reg : 16'd0;
                {n_next, z_next} = nz(wb_val, 1'b0);
                if (inreg_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = wb_val;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wd = wb_val;
                end
            end
            OP_TST_NZ:
            begin
                {n_next, z_next} = nz(dv_reg, byte_op);
            end
            OP_HALT:
            begin
                h_next = 1'b1;
            end
            OP_SOB1:
            begin
                wr_en   = 1'b1;
                wr_idx  = rr;
                wr_data = rval - 16'd1;
            end
            OP_SOB2:
            begin
                wr_en   = (rval != 16'd0);
                wr_idx  = 3'd7;
                wr_data = r7 - {9'd0, ir_reg[5:0], 1'b0};
            end
            OP_BRANCH:
            begin
                take = (kind == K_BR) || (kind == K_BEQ && z_reg) ||
                       (kind == K_BPL && !n_reg);
                wr_en   = take;
                wr_idx  = 3'd7;
                wr_data = r7 + {boff[14:0], 1'b0};
            end
            OP_JSR1:
            begin
                wr_en   = 1'b1;
                wr_idx  = 3'd6;
                wr_data = r6 - 16'd2;
            end
            OP_JSR2:
            begin
                mem_we  = 1'b1;
                mem_wa  = r6;
                mem_wd  = rval;
                wr_en   = 1'b1;
                wr_idx  = rr;
                wr_data = r7;
            end
            OP_JSR3:
            begin
                wr_en   = 1'b1;
                wr_idx  = 3'd7;
                wr_data = addr_reg;
            end
            OP_RTS1:
            begin
                mem_ra  = r6;
                wr_en   = 1'b1;
                wr_idx  = 3'd7;
                wr_data = rval;
            end
            OP_RTS2:
            begin
                wr_en   = 1'b1;
                wr_data = rword;
            end
            OP_RTS3:
            begin
                wr_en   = 1'b1;
                wr_idx  = 3'd6;
                wr_data = r6 + 16'd2;
            end
            OP_DONE:
            begin
                out_next.instr_address = iaddr_reg;
                out_next.instr_word    = ir_reg;
                out_next.instr_kind    = load_item_reg ? K_LOAD :
                                         (halt_snap_reg ? K_HALT : kind);
                out_next.halted        = h_reg;
                out_next.char_valid    = cvalid_reg;
                out_next.char_out      = char_reg;
                out_next.flag_n        = n_reg;
                out_next.flag_z        = z_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= (i == 7) ? PC_RESET : 16'd0;
            end
            n_reg       <= 1'b0;
            z_reg       <= 1'b0;
            h_reg       <= 1'b0;
            console_reg <= CONSOLE_RESET;
        end
        else
        begin
            if (wr_en)
            begin
                rf_reg[wr_idx] <= wr_data;
            end
            n_reg <= n_next;
            z_reg <= z_next;
            h_reg <= h_next;
            if (cfg_write_en)
            begin
                console_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg        <= ir_next;
        addr_reg      <= addr_next;
        inreg_reg     <= inreg_next;
        sv_reg        <= sv_next;
        dv_reg        <= dv_next;
        iaddr_reg     <= iaddr_next;
        lbyte_reg     <= lbyte_next;
        load_item_reg <= load_item_next;
        halt_snap_reg <= halt_snap_next;
        cvalid_reg    <= cvalid_next;
        char_reg      <= char_next;
        out_reg       <= out_next;
        rd_a0_reg     <= mem_ra[0];
    end

    // even bytes in one bank, odd bytes in the other
    assign we_lo = mem_we && (mem_word || !mem_wa[0]);
    assign we_hi = mem_we && (mem_word || mem_wa[0]);
    assign wd_hi = mem_word ? mem_wd[15:8] : mem_wd[7:0];

    always_ff @(posedge clk)
    begin
        if (we_lo)
        begin
            lo_mem[mem_wa[MEM_AW-1:1]] <= mem_wd[7:0];
        end
        rd_lo_reg <= lo_mem[mem_ra[MEM_AW-1:1]];
    end

    always_ff @(posedge clk)
    begin
        if (we_hi)
        begin
            hi_mem[mem_wa[MEM_AW-1:1]] <= wd_hi;
        end
        rd_hi_reg <= hi_mem[mem_ra[MEM_AW-1:1]];
    end

    assign out_data = out_reg;

endmodule

>>> hdl/pdp11_subset_cpu_step_unit.sv
// ----------------------------------------------------------------------------
// pdp11_subset_cpu_step_unit
// Executes one PDP-11 subset instruction, or loads one memory byte, per item.
// ----------------------------------------------------------------------------
// a load runs the load and done states; a step runs fetch, decode, operand and
//   execute states (straight to done once halted), paced by the memory port, one
//   access per cycle, registered reads; index/deferred reads and JSR/RTS add steps
// throughput: one transaction at a time; the next is taken on return to idle
// reset: registers clear, PC is 512, flags and halt clear, console address
//   is 65398; memory contents are undefined until written, no clearing pass
module pdp11_subset_cpu_step_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  p11s_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output p11s_pkg::out_item_t  out_data,
    input  logic                 cfg_write_en,
    input  logic [15:0]          cfg_write_data
);
    import p11s_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    p11s_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_data.opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    p11s_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_data        (in_data),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

endmodule

>>> dv/pdp11_subset_cpu_step_unit_tb.sv
// ----------------------------------------------------------------------------
// pdp11_subset_cpu_step_unit_tb
// Self-checking bench: byte loads and single steps of small programs, each
// result checked against an in-bench instruction-level model of the CPU.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pdp11_subset_cpu_step_unit_tb;
    import p11s_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct {
        bit          in_reg;
        logic [2:0]  rn;
        logic [15:0] addr;
    } operand_t;

    typedef struct {
        logic [15:0] a;
        logic [7:0]  v;
        bit          w;
    } undo_t;

    typedef struct {
        bit          is_step;
        logic [15:0] a;
        logic [15:0] w;
        bit          has_ext;
        logic [15:0] ext;
        bit          typed;
    } dir_row_t;

    localparam logic [15:0] OPC_MASK [13] = '{
        16'hFFFF, 16'o170000, 16'o170000, 16'o170000, 16'o177000, 16'o177700,
        16'o177400, 16'o177400, 16'o177400, 16'o177700, 16'o177700,
        16'o177000, 16'o177770
    };
    localparam logic [15:0] OPC_MATCH [13] = '{
        16'o000000, 16'o010000, 16'o110000, 16'o060000, 16'o077000,
        16'o005000, 16'o001400, 16'o100000, 16'o000400, 16'o005700,
        16'o105700, 16'o004000, 16'o000200
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_write_en;
    logic [15:0] cfg_write_data;

    pdp11_subset_cpu_step_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data)
    );

    // cpu model state
    logic [15:0] gpr [8];
    logic [7:0]  ram [65536];
    bit          ram_known [65536];
    bit          neg_f, zero_f, halt_f;
    logic [15:0] console_addr;
    bit          probing;
    undo_t       undo_log [$];
    logic [15:0] unknown_reads [$];

    out_item_t   pending_results [$];
    int          error_count;
    int          items_sent;
    int          steps_sent;
    int          console_chars;
    int          burst_left;
    longint      cycle_count;

    function automatic logic [15:0] sx8(logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    // branch displacement in bytes
    function automatic logic [15:0] br_disp(logic [7:0] v);
        return {{7{v[7]}}, v, 1'b0};
    endfunction

    function automatic logic [7:0] ram_rd(logic [15:0] a);
        if (!ram_known[a])
            unknown_reads.push_back(a);
        return ram[a];
    endfunction

    function automatic void ram_wr(logic [15:0] a, logic [7:0] v);
        if (probing)
            undo_log.push_back('{a, ram[a], ram_known[a]});
        ram[a] = v;
        ram_known[a] = 1'b1;
    endfunction

    function automatic logic [15:0] word_rd(logic [15:0] a);
        logic [15:0] e;
        logic [7:0]  lo;
        e = a & 16'hFFFE;
        lo = ram_rd(e);
        return {ram_rd(e + 16'd1), lo};
    endfunction

    function automatic void word_wr(logic [15:0] a, logic [15:0] v);
        logic [15:0] e;
        e = a & 16'hFFFE;
        ram_wr(e, v[7:0]);
        ram_wr(e + 16'd1, v[15:8]);
    endfunction

    function automatic logic [15:0] next_word();
        logic [15:0] x;
        x = word_rd(gpr[7]);
        gpr[7] = gpr[7] + 16'd2;
        return x;
    endfunction

    function automatic operand_t resolve_ea(logic [5:0] spec, bit bw);
        operand_t    op;
        logic [2:0]  rn;
        logic [15:0] stp;
        logic [15:0] x;
        rn = spec[2:0];
        stp = (bw && rn < 3'd6) ? 16'd1 : 16'd2;
        op = '{1'b0, rn, 16'd0};
        case (spec[5:3])
            3'd0: op.in_reg = 1'b1;
            3'd1: op.addr = gpr[rn];
            3'd2:
            begin
                op.addr = gpr[rn];
                gpr[rn] = gpr[rn] + stp;
            end
            3'd3:
            begin
                op.addr = word_rd(gpr[rn]);
                gpr[rn] = gpr[rn] + 16'd2;
            end
            3'd4:
            begin
                gpr[rn] = gpr[rn] - stp;
                op.addr = gpr[rn];
            end
            3'd5:
            begin
                gpr[rn] = gpr[rn] - 16'd2;
                op.addr = word_rd(gpr[rn]);
            end
            3'd6:
            begin
                x = next_word();
                op.addr = gpr[rn] + x;
            end
            default:
            begin
                x = next_word();
                op.addr = word_rd(gpr[rn] + x);
            end
        endcase
        return op;
    endfunction

    function automatic logic [15:0] operand_rd(operand_t op, bit bw);
        if (op.in_reg)
            return bw ? sx8(gpr[op.rn][7:0]) : gpr[op.rn];
        return bw ? sx8(ram_rd(op.addr)) : word_rd(op.addr);
    endfunction

    function automatic void operand_wr(operand_t op, bit bw, logic [15:0] v);
        if (op.in_reg)
            gpr[op.rn] = bw ? sx8(v[7:0]) : v;
        else if (bw)
            ram_wr(op.addr, v[7:0]);
        else
            word_wr(op.addr, v);
    endfunction

    function automatic void update_nz(logic [15:0] v, bit bw);
        neg_f = bw ? v[7] : v[15];
        zero_f = bw ? (v[7:0] == 8'd0) : (v == 16'd0);
    endfunction

    // executes one transaction on the model and returns the result it gives
    function automatic out_item_t cpu_execute(in_item_t it);
        out_item_t   r;
        kind_t       k;
        logic [15:0] w, sv, dv;
        logic [2:0]  rr;
        operand_t    s, d;
        bit          bw;
        r = '0;
        w = 16'd0;
        if (!it.opcode)
        begin
            ram_wr(it.load_address, it.load_byte);
            r.instr_address = it.load_address;
            k = K_LOAD;
        end
        else if (halt_f)
        begin
            r.instr_address = gpr[7];
            k = K_HALT;
        end
        else
        begin
            r.instr_address = gpr[7];
            w = next_word();
            k = K_UNKNOWN;
            for (int i = 12; i >= 0; i--)
            begin
                if ((w & OPC_MASK[i]) == OPC_MATCH[i])
                    k = kind_t'(4'(i));
            end
            bw = w[15];
            rr = w[8:6];
            case (k)
                K_HALT: halt_f = 1'b1;
                K_MOV, K_MOVB:
                begin
                    s = resolve_ea(w[11:6], bw);
                    sv = operand_rd(s, bw);
                    d = resolve_ea(w[5:0], bw);
                    update_nz(sv, bw);
                    if (!d.in_reg && d.addr == console_addr)
                    begin
                        r.char_valid = 1'b1;
                        r.char_out = sv[7:0];
                    end
                    else
                    begin
                        operand_wr(d, bw, sv);
                    end
                end
                K_ADD:
                begin
                    s = resolve_ea(w[11:6], 1'b0);
                    sv = operand_rd(s, 1'b0);
                    d = resolve_ea(w[5:0], 1'b0);
                    dv = operand_rd(d, 1'b0) + sv;
                    operand_wr(d, 1'b0, dv);
                    update_nz(dv, 1'b0);
                end
                K_SOB:
                begin
                    gpr[rr] = gpr[rr] - 16'd1;
                    if (gpr[rr] != 16'd0)
                        gpr[7] = gpr[7] - {9'd0, w[5:0], 1'b0};
                end
                K_CLR:
                begin
                    d = resolve_ea(w[5:0], 1'b0);
                    operand_wr(d, 1'b0, 16'd0);
                    neg_f = 1'b0;
                    zero_f = 1'b1;
                end
                K_BEQ: if (zero_f) gpr[7] = gpr[7] + br_disp(w[7:0]);
                K_BPL: if (!neg_f) gpr[7] = gpr[7] + br_disp(w[7:0]);
                K_BR: gpr[7] = gpr[7] + br_disp(w[7:0]);
                K_TST, K_TSTB:
                begin
                    d = resolve_ea(w[5:0], bw);
                    update_nz(operand_rd(d, bw), bw);
                end
                K_JSR:
                begin
                    // register destination: nothing beyond the fetch
                    if (w[5:3] != 3'd0)
                    begin
                        d = resolve_ea(w[5:0], 1'b0);
                        gpr[6] = gpr[6] - 16'd2;
                        word_wr(gpr[6], gpr[rr]);
                        gpr[rr] = gpr[7];
                        gpr[7] = d.addr;
                    end
                end
                K_RTS:
                begin
                    rr = w[2:0];
                    gpr[7] = gpr[rr];
                    gpr[rr] = word_rd(gpr[6]);
                    gpr[6] = gpr[6] + 16'd2;
                end
                default: ;
            endcase
        end
        r.instr_word = w;
        r.instr_kind = k;
        r.halted = halt_f;
        r.flag_n = neg_f;
        r.flag_z = zero_f;
        return r;
    endfunction

    // dry run of a step: collects reads of never-written bytes, then undoes all
    function automatic void probe_step();
        logic [15:0] saved [8];
        bit          sn, sz, sh;
        in_item_t    it;
        undo_t       u;
        saved = gpr;
        sn = neg_f;
        sz = zero_f;
        sh = halt_f;
        it = '{1'b1, 16'd0, 8'd0};
        probing = 1'b1;
        undo_log.delete();
        unknown_reads.delete();
        void'(cpu_execute(it));
        while (undo_log.size() != 0)
        begin
            u = undo_log.pop_back();
            ram[u.a] = u.v;
            ram_known[u.a] = u.w;
        end
        probing = 1'b0;
        gpr = saved;
        neg_f = sn;
        zero_f = sz;
        halt_f = sh;
    endfunction

    // drives one transaction; bursts of back-to-back items with random gaps
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
        out_item_t r;
        r = cpu_execute(it);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
        if (it.opcode)
            steps_sent++;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic load_byte_at(logic [15:0] a, logic [7:0] v);
        send_item('{1'b0, a, v}, 1'b0, '0);
    endtask

    task automatic load_word_at(logic [15:0] a, logic [15:0] v);
        load_byte_at(a & 16'hFFFE, v[7:0]);
        load_byte_at((a & 16'hFFFE) + 16'd1, v[15:8]);
    endtask

    // places an instruction at PC, backfills every never-written byte it would read, steps
    task automatic run_instr(logic [15:0] w, bit has_ext, logic [15:0] ext);
        logic [15:0] holes [$];
        load_word_at(gpr[7], w);
        if (has_ext)
            load_word_at(gpr[7] + 16'd2, ext);
        for (int n = 0; n < 64; n++)
        begin
            probe_step();
            if (unknown_reads.size() == 0)
                break;
            holes = unknown_reads;
            foreach (holes[i])
            begin
                if (!ram_known[holes[i]])
                    load_byte_at(holes[i], 8'($urandom));
            end
        end
        send_item('{1'b1, 16'($urandom), 8'($urandom)}, 1'b0, '0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_console(logic [15:0] v);
        drain_results();
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        console_addr = v;
        @(posedge clk);
    endtask

    task automatic random_instr();
        logic [15:0] w, ext;
        bit          has_ext;
        has_ext = 1'b0;
        ext = 16'd0;
        case ($urandom_range(0, 13))
            0: w = 16'o010000 | 16'($urandom_range(0, 4095));
            1: w = 16'o110000 | 16'($urandom_range(0, 4095));
            2: w = 16'o060000 | 16'($urandom_range(0, 4095));
            3: w = 16'o077000 | 16'($urandom_range(0, 511));
            4: w = 16'o005000 | 16'($urandom_range(0, 63));
            5: w = 16'o001400 | 16'($urandom_range(0, 255));
            6: w = 16'o100000 | 16'($urandom_range(0, 255));
            7: w = 16'o000400 | 16'($urandom_range(0, 255));
            8: w = 16'o005700 | 16'($urandom_range(0, 63));
            9: w = 16'o105700 | 16'($urandom_range(0, 63));
            10: w = 16'o004000 | 16'($urandom_range(0, 511));
            11: w = 16'o000200 | 16'($urandom_range(0, 7));
            12:
            begin
                // mov/movb rN,@#console
                w = ($urandom_range(0, 1) ? 16'o110000 : 16'o010000)
                    | 16'($urandom_range(0, 7) << 6) | 16'o000037;
                has_ext = 1'b1;
                ext = console_addr;
            end
            default: w = 16'($urandom_range(1, 65535));
        endcase
        run_instr(w, has_ext, ext);
    endtask

    function automatic void check_field(string name, logic [15:0] e, logic [15:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            error_count++;
        end
    endfunction

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: free-running, random, or periodic stretches
    int stall_mode;
    int stall_left;
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(20, 200);
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
            stall_phase <= stall_phase + 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 4);
                default: out_stall <= (stall_phase % 7) < 3;
            endcase
        end
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected transaction: actual %p", $time, out_data);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("instr_address", e.instr_address, out_data.instr_address);
                check_field("instr_word", e.instr_word, out_data.instr_word);
                check_field("instr_kind", 16'(e.instr_kind), 16'(out_data.instr_kind));
                check_field("halted", 16'(e.halted), 16'(out_data.halted));
                check_field("char_valid", 16'(e.char_valid), 16'(out_data.char_valid));
                check_field("char_out", 16'(e.char_out), 16'(out_data.char_out));
                check_field("flag_n", 16'(e.flag_n), 16'(out_data.flag_n));
                check_field("flag_z", 16'(e.flag_z), 16'(out_data.flag_z));
                if (e.char_valid)
                    console_chars++;
            end
        end
    end

    dir_row_t dir_rows [$];

    initial
    begin
        logic [15:0] con_vals [3];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write_en = 1'b0;
        cfg_write_data = 16'd0;
        error_count = 0;
        items_sent = 0;
        steps_sent = 0;
        console_chars = 0;
        burst_left = 0;
        cycle_count = 0;
        probing = 1'b0;
        foreach (gpr[i])
            gpr[i] = 16'd0;
        gpr[7] = 16'd512;
        neg_f = 1'b0;
        zero_f = 1'b0;
        halt_f = 1'b0;
        console_addr = 16'd65398;
        foreach (ram_known[i])
            ram_known[i] = 1'b0;

        // loads at the address and byte extremes, then one of every instruction but halt
        dir_rows = '{
            '{1'b0, 16'h0000, 16'h00FF, 1'b0, 16'h0, 1'b1},
            '{1'b0, 16'hFFFF, 16'h0000, 1'b0, 16'h0, 1'b1},
            '{1'b0, 16'h8000, 16'h00AA, 1'b0, 16'h0, 1'b1},
            '{1'b0, 16'h7FFF, 16'h0055, 1'b0, 16'h0, 1'b1},
            '{1'b1, 16'h0, 16'o012700, 1'b1, 16'h8000, 1'b0},  // mov #,r0
            '{1'b1, 16'h0, 16'o112701, 1'b1, 16'h0080, 1'b0},  // movb # sign-extends
            '{1'b1, 16'h0, 16'o060001, 1'b0, 16'h0, 1'b0},     // add r0,r1
            '{1'b1, 16'h0, 16'o077102, 1'b0, 16'h0, 1'b0},     // sob r1
            '{1'b1, 16'h0, 16'o005000, 1'b0, 16'h0, 1'b0},     // clr r0
            '{1'b1, 16'h0, 16'o001401, 1'b0, 16'h0, 1'b0},     // beq taken
            '{1'b1, 16'h0, 16'o100001, 1'b0, 16'h0, 1'b0},     // bpl taken
            '{1'b1, 16'h0, 16'o000777, 1'b0, 16'h0, 1'b0},     // br backwards
            '{1'b1, 16'h0, 16'o005701, 1'b0, 16'h0, 1'b0},     // tst r1
            '{1'b1, 16'h0, 16'o105701, 1'b0, 16'h0, 1'b0},     // tstb r1
            '{1'b1, 16'h0, 16'o112600, 1'b0, 16'h0, 1'b0},     // movb (sp)+ steps 2
            '{1'b1, 16'h0, 16'o114203, 1'b0, 16'h0, 1'b0},     // movb -(r2) steps 1
            '{1'b1, 16'h0, 16'o017700, 1'b0, 16'h0, 1'b0},     // mode 7
            '{1'b1, 16'h0, 16'o010037, 1'b1, 16'd65398, 1'b0}, // console
            '{1'b1, 16'h0, 16'o004100, 1'b0, 16'h0, 1'b0},     // jsr, reg dest
            '{1'b1, 16'h0, 16'o004767, 1'b1, 16'h0010, 1'b0},  // jsr pc,x(pc)
            '{1'b1, 16'h0, 16'o000207, 1'b0, 16'h0, 1'b0},     // rts pc
            '{1'b1, 16'h0, 16'o007000, 1'b0, 16'h0, 1'b0}      // no match
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_step)
                run_instr(dir_rows[i].w, dir_rows[i].has_ext, dir_rows[i].ext);
            else
                send_item('{1'b0, dir_rows[i].a, dir_rows[i].w[7:0]}, dir_rows[i].typed,
                          '{dir_rows[i].a, 16'd0, K_LOAD, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0});
        end

        // random programs in four console settings; the block is idle at each change
        con_vals = '{16'h0000, 16'hFFFF, 16'($urandom)};
        for (int ph = 0; ph < 4; ph++)
        begin
            int stop_at;
            if (ph > 0)
                write_console(con_vals[ph - 1]);
            stop_at = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < stop_at)
            begin
                if ($urandom_range(0, 9) == 0)
                    load_byte_at(16'($urandom), 8'($urandom));
                else
                    random_instr();
                if ($urandom_range(0, 299) == 0)
                    drain_results();
            end
        end

        // halt, a step while halted, and a load while halted
        drain_results();
        run_instr(16'o000000, 1'b0, 16'd0);
        send_item('{1'b1, 16'hFFFF, 8'hFF}, 1'b0, '0);
        send_item('{1'b0, 16'h1234, 8'h5A}, 1'b0, '0);
        send_item('{1'b1, 16'h0000, 8'h00}, 1'b0, '0);

        drain_results();
        repeat (30) @(posedge clk);
        $display("covered %0d transactions, %0d instruction steps, %0d console characters",
                 items_sent, steps_sent, console_chars);
        $display("console address settings: reset, 0000, ffff and one random value");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
hdl/p11s_pkg.sv
hdl/p11s_ctrl.sv
hdl/p11s_dpath.sv
hdl/pdp11_subset_cpu_step_unit.sv
dv/pdp11_subset_cpu_step_unit_tb.sv
